// File: rtl/rdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_pkg: shared types and constants of the retransmit drop filter
// Holds the command codes, the segment key layout and the queued item format.
// ----------------------------------------------------------------------------
package rdf_pkg;

  localparam int KeyW  = 128;
  localparam int WordW = 32;
  localparam int PortW = 16;

  localparam logic [1:0] CMD_MARK    = 2'd0;
  localparam logic [1:0] CMD_CONFIRM = 2'd1;
  localparam logic [1:0] CMD_PACKET  = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic CFG_DST_ADDR = 1'b0;
  localparam logic CFG_DST_PORT = 1'b1;

  // classified item, as handed from the front end to the table engine
  typedef struct packed {
    logic [1:0]       cmd;
    logic             aimed;    // IPv4 and destination matches the filter
    logic             pkt_ok;   // TCP, unicast, all headers present
    logic [KeyW-1:0]  key;      // {seq, dport, dst_addr, sport, src_addr}
    logic [WordW-1:0] ack;
    logic [WordW-1:0] status;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/rdf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_front: item intake and classification
// Classify each incoming item against the filter and hold it in a two-entry
// queue until the table engine takes it.
// ----------------------------------------------------------------------------
module rdf_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [5:0]                in_user_i,
  input  wire logic [191:0]              in_data_i,
  input  wire logic [rdf_pkg::WordW-1:0] match_addr_i,
  input  wire logic [rdf_pkg::PortW-1:0] match_port_i,
  output logic                           head_valid_o,
  input  wire logic                      head_pop_i,
  output rdf_pkg::item_t                 head_o
);
  import rdf_pkg::*;

  item_t      fifo_q [2];
  item_t      in_item;
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  always_comb begin
    in_item.cmd    = in_user_i[1:0];
    in_item.aimed  = in_user_i[2] && (in_data_i[79:48] == match_addr_i)
                     && (in_data_i[95:80] == match_port_i);
    in_item.pkt_ok = in_user_i[3] && !in_user_i[4] && in_user_i[5];
    in_item.key    = in_data_i[127:0];
    in_item.ack    = in_data_i[159:128];
    in_item.status = in_data_i[191:160];
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = head_pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rdf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_back: key table engine
// For an item aimed at the filter, scan the key memory one entry a cycle, then
// insert, delete or flag it; register the result of every item.
// ----------------------------------------------------------------------------
module rdf_back #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  output logic                head_pop_o,
  input  rdf_pkg::item_t      head_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          out_user_o,
  output logic [191:0]        out_data_o
);
  import rdf_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [KeyW-1:0]          mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [1:0]               state_q, state_d;
  item_t                    cur_q;
  logic [AW-1:0]            ptr_q, ptr_d;
  logic                     rd_pend_q;
  logic [AW-1:0]            rd_idx_q;
  logic                     rd_vld_q;
  logic [KeyW-1:0]          rd_key_q;
  logic                     found_q, free_q;
  logic [AW-1:0]            found_idx_q, free_idx_q;
  logic                     out_valid_q, out_valid_d;
  logic [1:0]               out_user_q;
  logic [191:0]             out_data_q;
  logic                     issue, finish, wr_en;

  assign head_pop_o  = (state_q == ST_IDLE) && head_valid_i;
  assign issue       = (state_q == ST_SCAN);
  assign finish      = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign wr_en       = finish && (cur_q.cmd == CMD_MARK) && !found_q && free_q;
  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_user_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          state_d = head_i.aimed ? ST_SCAN : ST_FIN;
          ptr_d   = '0;
        end
      end
      ST_SCAN: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == AW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: state_d = ST_FIN;
      ST_FIN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (wr_en) begin
      valid_d[free_idx_q] = 1'b1;
    end else if (finish && (cur_q.cmd == CMD_CONFIRM) && found_q) begin
      valid_d[found_idx_q] = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      valid_q     <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      valid_q     <= valid_d;
      rd_pend_q   <= issue;
      out_valid_q <= out_valid_d;
      if (head_pop_o) begin
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (rd_pend_q) begin
        if (rd_vld_q && (rd_key_q == cur_q.key) && !found_q) begin
          found_q <= 1'b1;
        end
        if (!rd_vld_q && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // key memory: one read a cycle during the scan, one write at the end
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[free_idx_q] <= cur_q.key;
    end
    rd_key_q <= mem_q[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      cur_q <= head_i;
    end
    rd_idx_q <= ptr_q;
    rd_vld_q <= valid_q[ptr_q];
    if (rd_pend_q) begin
      if (rd_vld_q && (rd_key_q == cur_q.key) && !found_q) begin
        found_idx_q <= rd_idx_q;
      end
      if (!rd_vld_q && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
    if (finish) begin
      out_user_q[0] <= (cur_q.cmd == CMD_CONFIRM) && found_q;
      out_user_q[1] <= (cur_q.cmd == CMD_PACKET) && cur_q.pkt_ok && found_q;
      if ((cur_q.cmd == CMD_CONFIRM) && found_q) begin
        out_data_q <= {cur_q.status, cur_q.ack, cur_q.key};
      end else begin
        out_data_q <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/retransmit_drop_filter.sv
`default_nettype none
// Flow: an item aimed at the filter goes from the queue through the key memory
//   scan, one entry per cycle through a single read port, to a registered result;
//   any other item skips the scan. The engine takes one item at a time, while the
//   front queue holds up to two more.
// Reset: rst_ni asynchronous active low; clears all table entries (valid bits),
//   the queue and the output; filter address and port return to defaults.
// ----------------------------------------------------------------------------
// retransmit_drop_filter: table of TCP segments under retransmission
// Mark events insert keys, confirm events delete them and emit a record,
// packet headers whose key is present are dropped.
// ----------------------------------------------------------------------------
module retransmit_drop_filter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // cfg: index 0 match_dst_addr, index 1 match_dst_port
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tuser: cmd[1:0], is_ipv4[2], is_tcp[3], group_cast[4], headers_fit[5]
  input  wire logic [5:0]   s_axis_tuser,
  // tdata: src_addr, sport, dst_addr, dport, seq_num, ack_num,
  //        call_status
  input  wire logic [191:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tuser: record_valid[0], drop[1]
  output logic [1:0]        m_axis_tuser,
  // tdata: rec_src_addr, rec_sport, rec_dst_addr, rec_dport, rec_seq,
  //        rec_ack, rec_status
  output logic [191:0]      m_axis_tdata
);
  import rdf_pkg::*;

  logic [WordW-1:0] match_addr_q;
  logic [PortW-1:0] match_port_q;
  logic             head_valid, head_pop;
  item_t            head;

  // filter registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_addr_q <= 32'h0A28_2A03;
      match_port_q <= 16'd5201;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DST_ADDR: match_addr_q <= cfg_data_i;
        CFG_DST_PORT: match_port_q <= cfg_data_i[PortW-1:0];
        default: ;
      endcase
    end
  end

  // front: classify and queue
  rdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_user_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .match_addr_i (match_addr_q),
    .match_port_i (match_port_q),
    .head_valid_o (head_valid),
    .head_pop_i   (head_pop),
    .head_o       (head)
  );

  // back: table scan and update, registered result
  rdf_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .head_i       (head),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_user_o   (m_axis_tuser),
    .out_data_o   (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // a record and a drop never come from the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("record and drop both set");

  // record fields are zero unless a record is emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("record fields set without record");
`endif

endmodule
`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the retransmit drop filter
// Drives mark, confirm and packet items over the input stream, predicts each
// result with an own copy of the segment table and the filter registers, and
// compares every output item field by field under varying backpressure.
// ----------------------------------------------------------------------------
module testbench;
  import rdf_pkg::*;

  localparam int Entries  = 64;
  localparam int PoolSize = 80;
  localparam int Settle   = Entries + 16;

  typedef struct {
    logic [5:0]   user;
    logic [191:0] data;
  } in_item_t;

  typedef struct {
    logic [1:0]   user;
    logic [191:0] data;
  } out_item_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = CFG_DST_ADDR;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tuser: cmd[1:0], is_ipv4[2], is_tcp[3], group_cast[4], headers_fit[5]
  logic [5:0]   s_axis_tuser = '0;
  // tdata: src_addr, sport, dst_addr, dport, seq_num, ack_num, call_status
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tuser: record_valid[0], drop[1]
  logic [1:0]   m_axis_tuser;
  // tdata: rec_src_addr, rec_sport, rec_dst_addr, rec_dport, rec_seq,
  //        rec_ack, rec_status
  logic [191:0] m_axis_tdata;

  retransmit_drop_filter #(.TABLE_ENTRIES(Entries)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the segment table and the filter registers
  logic [KeyW-1:0]  seg_key [Entries];
  logic             seg_live [Entries];
  logic [31:0]      filt_addr;
  logic [15:0]      filt_port;

  in_item_t         pending_q [$];
  out_item_t        record_q [$];
  logic [KeyW-1:0]  key_pool [PoolSize];
  int               errors = 0;
  int               send_gap_pct = 0;
  int               recv_stall_pct = 0;
  bit               hold_req = 1'b0;
  int               hold_cnt = 0;
  bit               in_fire = 1'b0;

  // Work out the result of one item and advance the shadow table.
  function automatic out_item_t filter_predict(in_item_t it);
    out_item_t       res;
    logic [1:0]      cmd;
    logic [KeyW-1:0] k;
    logic            aimed;
    int              hit;
    int              free_slot;
    cmd   = it.user[1:0];
    k     = it.data[127:0];
    res.user = '0;
    res.data = '0;
    aimed = it.user[2] && k[79:48] == filt_addr && k[95:80] == filt_port;
    hit = -1;
    free_slot = -1;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (seg_live[i] && seg_key[i] == k) hit = i;
      if (!seg_live[i]) free_slot = i;
    end
    if (aimed) begin
      case (cmd)
        CMD_MARK: begin
          // an existing key stays in place; a new one takes the lowest free slot
          if (hit < 0 && free_slot >= 0) begin
            seg_key[free_slot]  = k;
            seg_live[free_slot] = 1'b1;
          end
        end
        CMD_CONFIRM: begin
          if (hit >= 0) begin
            seg_live[hit] = 1'b0;
            res.user[0] = 1'b1;
            res.data = it.data;
          end
        end
        CMD_PACKET: begin
          if (it.user[3] && !it.user[4] && it.user[5] && hit >= 0) res.user[1] = 1'b1;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, logic v4, logic tcp,
                                         logic gc, logic fit, logic [KeyW-1:0] k,
                                         logic [31:0] ack, logic [31:0] st);
    in_item_t it;
    it.user = {fit, gc, tcp, v4, cmd};
    it.data = {st, ack, k};
    return it;
  endfunction

  function automatic logic [KeyW-1:0] aimed_key(logic [31:0] sa, logic [15:0] sp,
                                                logic [31:0] sq);
    return {sq, filt_port, filt_addr, sp, sa};
  endfunction

  // Random item: mostly well-formed traffic on the pool keys, some noise.
  function automatic in_item_t random_item();
    int              r;
    logic [KeyW-1:0] k;
    logic [1:0]      cmd;
    r = $urandom_range(0, 99);
    k = key_pool[$urandom_range(0, PoolSize - 1)];
    if (r >= 90)
      return make_item(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       1'($urandom), {$urandom, $urandom, $urandom, $urandom},
                       $urandom, $urandom);
    cmd = (r < 40) ? CMD_MARK : (r < 65) ? CMD_CONFIRM : CMD_PACKET;
    return make_item(cmd, $urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0,
                     $urandom_range(0, 9) == 0, $urandom_range(0, 9) != 0,
                     k, $urandom, $urandom);
  endfunction

  // Driver: advance to the next pending item, with random gaps.
  always @(negedge clk_i) begin
    logic nv;
    nv = s_axis_tvalid;
    if (s_axis_tvalid && in_fire) nv = 1'b0;
    if (!nv && rst_ni && pending_q.size() > 0 &&
        $urandom_range(0, 99) >= send_gap_pct) begin
      in_item_t it;
      it = pending_q.pop_front();
      s_axis_tuser <= it.user;
      s_axis_tdata <= it.data;
      nv = 1'b1;
    end
    s_axis_tvalid <= nv;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  localparam int FieldOff [7] = '{0, 32, 48, 80, 96, 128, 160};
  localparam int FieldW   [7] = '{32, 16, 32, 16, 32, 32, 32};

  // Monitor: predict on input accept, check on output accept.
  always @(posedge clk_i) begin
    in_fire = s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      in_item_t it;
      it.user = s_axis_tuser;
      it.data = s_axis_tdata;
      record_q.push_back(filter_predict(it));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (record_q.size() == 0) begin
        $display("%0t: unexpected result tuser=%h tdata=%h", $time, m_axis_tuser,
                 m_axis_tdata);
        errors++;
      end else begin
        out_item_t ex;
        ex = record_q.pop_front();
        for (int b = 0; b < 2; b++)
          if (ex.user[b] !== m_axis_tuser[b]) begin
            $display("%0t: tuser[%0d] expected %b actual %b", $time, b, ex.user[b],
                     m_axis_tuser[b]);
            errors++;
          end
        for (int f = 0; f < 7; f++) begin
          logic [31:0] e;
          logic [31:0] a;
          e = 32'((ex.data >> FieldOff[f]) & ((192'd1 << FieldW[f]) - 1));
          a = 32'((m_axis_tdata >> FieldOff[f]) & ((192'd1 << FieldW[f]) - 1));
          if (e !== a) begin
            $display("%0t: tdata field %0d expected %h actual %h", $time, f, e, a);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == CFG_DST_ADDR) filt_addr = value;
    else filt_port = value[15:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid && record_q.size() == 0);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic random_phase(int n, int gap, int stall, bit press);
    for (int i = 0; i < PoolSize; i++)
      key_pool[i] = aimed_key($urandom, 16'($urandom), $urandom_range(0, 3) == 0 ?
                              32'(i) : $urandom);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_q.push_back(random_item());
    if (press) hold_req = 1'b1;
    drain();
  endtask

  initial begin
    logic [KeyW-1:0] ka;
    logic [KeyW-1:0] kb;
    for (int i = 0; i < Entries; i++) begin
      seg_live[i] = 1'b0;
      seg_key[i]  = '0;
    end
    filt_addr = 32'h0A28_2A03;
    filt_port = 16'd5201;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pass conditions, overwrite, confirm hit and miss, filtered
    // events, the unused command, field extremes.
    ka = aimed_key('0, '0, '0);
    kb = aimed_key('1, '1, '1);
    pending_q.push_back(make_item(CMD_MARK,    1, 0, 1, 0, ka, '0, '0));
    pending_q.push_back(make_item(CMD_PACKET,  1, 1, 0, 1, ka, '0, '0));
    pending_q.push_back(make_item(CMD_PACKET,  1, 0, 0, 1, ka, '0, '0));
    pending_q.push_back(make_item(CMD_PACKET,  1, 1, 1, 1, ka, '0, '0));
    pending_q.push_back(make_item(CMD_PACKET,  1, 1, 0, 0, ka, '0, '0));
    pending_q.push_back(make_item(CMD_PACKET,  0, 1, 0, 1, ka, '0, '0));
    pending_q.push_back(make_item(CMD_MARK,    1, 1, 0, 1, ka, '1, '1));
    pending_q.push_back(make_item(CMD_CONFIRM, 1, 1, 1, 1, ka, '1, 32'h8000_0000));
    pending_q.push_back(make_item(CMD_CONFIRM, 1, 0, 0, 0, ka, '1, '1));
    pending_q.push_back(make_item(CMD_PACKET,  1, 1, 0, 1, ka, '0, '0));
    pending_q.push_back(make_item(CMD_MARK,    1, 1, 1, 1, kb, '0, '0));
    pending_q.push_back(make_item(CMD_MARK,    1, 1, 0, 1, kb ^ (128'd1 << 80), '0, '0));
    pending_q.push_back(make_item(CMD_CONFIRM, 1, 1, 0, 1, kb ^ (128'd1 << 80), '0, '0));
    pending_q.push_back(make_item(CMD_CONFIRM, 0, 1, 0, 1, kb, '0, '0));
    pending_q.push_back(make_item(CMD_NONE,    1, 1, 0, 1, kb, '1, '1));
    pending_q.push_back(make_item(CMD_PACKET,  1, 1, 0, 1, kb, '1, '1));
    pending_q.push_back(make_item(CMD_CONFIRM, 1, 1, 0, 1, kb, '0, 32'h7FFF_FFFF));
    pending_q.push_back(make_item(CMD_PACKET,  1, 1, 0, 1, kb, '1, '1));
    drain();

    // Random phases over several filter settings and idle patterns
    random_phase(80, 0, 0, 0);
    write_reg(CFG_DST_ADDR, '0);
    write_reg(CFG_DST_PORT, '0);
    random_phase(80, 57, 0, 0);
    write_reg(CFG_DST_ADDR, '1);
    write_reg(CFG_DST_PORT, 32'h0000_FFFF);
    random_phase(80, 0, 57, 0);
    write_reg(CFG_DST_ADDR, $urandom);
    write_reg(CFG_DST_PORT, $urandom);
    random_phase(80, 21, 21, 0);
    random_phase(80, 0, 0, 1);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hold a generous ceiling on the run.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/rdf_pkg.sv
rtl/rdf_front.sv
rtl/rdf_back.sv
rtl/retransmit_drop_filter.sv
bench/testbench.sv
